FILE: hw/rtl/two_class_fifo_oldest_first_defines.svh
// Assertion macros shared by the two-class queue RTL.
// Needs no other file; include it by its bare file name.
`ifndef TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH
`define TWO_CLASS_FIFO_OLDEST_FIRST_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define TFQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define TFQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tfq_pkg.sv
// Package for the two-class queue: transaction types, codes and defaults.
// Has no dependencies; used by the queue top level and its RAM.
package tfq_pkg;

	localparam int unsigned QueueDepthDefault  = 16;
	localparam int unsigned PayloadBitsDefault = 16;
	localparam int unsigned SeqBitsDefault     = 16;

	// Command codes.
	localparam logic [1:0] CMD_PUSH    = 2'd0;
	localparam logic [1:0] CMD_POP     = 2'd1;
	localparam logic [1:0] CMD_POP_ANY = 2'd2;

	// Status codes.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_EMPTY = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        item_class;
		logic [15:0] payload_id;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_payload;
		logic        out_class;
	} rsp_t;

endpackage

FILE: hw/rtl/tfq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on tfq_pkg only for its default sizes.
module tfq_ram #(
	parameter int unsigned WIDTH = tfq_pkg::PayloadBitsDefault + tfq_pkg::SeqBitsDefault,
	parameter int unsigned DEPTH = tfq_pkg::QueueDepthDefault
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/two_class_fifo_oldest_first.sv
// Two-class FIFO with oldest-first dequeue.
// Depends on tfq_pkg, tfq_ram and two_class_fifo_oldest_first_defines.svh.
//
// Usage: the request channel (req_valid, req_stall, req) carries one command per
// transaction: push a payload id into class 0 or class 1, pop the head of a given
// class, or pop whichever head is older. Every request produces exactly one
// response transaction on the response channel (rsp_valid, rsp_stall, rsp) with a
// status (ok, pop from empty, push into full) and, for a successful pop, the
// payload id and its class; other fields are zero.
// For each request, the head entries of both class RAMs are read in
// the cycle the request is accepted, and the registered RAM read puts the
// decision and the pointer update in the execute state that follows. A new request is
// not accepted until the previous one commits, and the response is written to the
// output register when it commits.
// The output register decouples the channels: a new request is accepted while a
// finished response still waits. If the receiver stalls with a response pending,
// the next request holds in its execute cycle until the register frees up.
// Reset clears all pointers, counts and the arrival sequence counter; the RAM
// contents are not cleared, as no entry is read before it has been written.
module two_class_fifo_oldest_first #(
	parameter int unsigned QUEUE_DEPTH  = tfq_pkg::QueueDepthDefault,
	parameter int unsigned PAYLOAD_BITS = tfq_pkg::PayloadBitsDefault,
	parameter int unsigned SEQ_BITS     = tfq_pkg::SeqBitsDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  tfq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output tfq_pkg::rsp_t rsp
);

	import tfq_pkg::*;

	`include "two_class_fifo_oldest_first_defines.svh"

	localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned EntW  = PAYLOAD_BITS + SEQ_BITS;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;

	// Request captured at acceptance.
	logic [1:0]              cmd_q;
	logic                    cls_q;
	logic [PAYLOAD_BITS-1:0] pay_q;

	// Queue bookkeeping, one set per class.
	logic [PtrW-1:0]     head0_q, tail0_q, head1_q, tail1_q;
	logic [CntW-1:0]     cnt0_q, cnt1_q;
	logic [SEQ_BITS-1:0] seq_q;

	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic            accept;
	logic            commit;
	logic [EntW-1:0] rd0, rd1;
	logic [EntW-1:0] wr_ent;
	logic            push0, push1, pop0, pop1;
	rsp_t            res;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	// The execute cycle finishes only when the output register can take the result.
	assign commit    = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign wr_ent = {seq_q, pay_q};

	// Each class RAM is read at its head when a request is accepted and written at
	// its tail when a push commits; the two never fall in the same cycle.
	tfq_ram #(.WIDTH(EntW), .DEPTH(QUEUE_DEPTH)) u_ram0 (
		.clk     (clk),
		.wr_en   (push0),
		.wr_addr (tail0_q),
		.wr_data (wr_ent),
		.rd_en   (accept),
		.rd_addr (head0_q),
		.rd_data (rd0)
	);

	tfq_ram #(.WIDTH(EntW), .DEPTH(QUEUE_DEPTH)) u_ram1 (
		.clk     (clk),
		.wr_en   (push1),
		.wr_addr (tail1_q),
		.wr_data (wr_ent),
		.rd_en   (accept),
		.rd_addr (head1_q),
		.rd_data (rd1)
	);

	// Decision logic for the execute cycle.
	always_comb begin
		logic                empty0, empty1, full0, full1;
		logic [SEQ_BITS-1:0] tag0, tag1, diff;
		logic                older1;
		logic                pick;
		logic                do_pop;
		logic                full_sel, empty_sel;

		empty0  = (cnt0_q == '0);
		empty1  = (cnt1_q == '0);
		full0   = (cnt0_q == CntW'(QUEUE_DEPTH));
		full1   = (cnt1_q == CntW'(QUEUE_DEPTH));
		tag0    = rd0[PAYLOAD_BITS +: SEQ_BITS];
		tag1    = rd1[PAYLOAD_BITS +: SEQ_BITS];
		// Class 1 is strictly older when the wrapped difference is negative.
		diff    = tag1 - tag0;
		older1  = diff[SEQ_BITS-1];
		pick    = cls_q;
		do_pop  = 1'b0;
		full_sel  = cls_q ? full1 : full0;
		empty_sel = 1'b0;
		res     = '0;
		push0   = 1'b0;
		push1   = 1'b0;

		case (cmd_q)
			CMD_PUSH: begin
				if (full_sel) begin
					res.status = STS_FULL;
				end else begin
					push0 = commit && !cls_q;
					push1 = commit && cls_q;
				end
			end
			CMD_POP: begin
				do_pop = 1'b1;
			end
			CMD_POP_ANY: begin
				pick   = !empty1 && (empty0 || older1);
				do_pop = 1'b1;
			end
			default: begin
			end
		endcase

		empty_sel = pick ? empty1 : empty0;
		pop0 = 1'b0;
		pop1 = 1'b0;
		if (do_pop) begin
			if (empty_sel) begin
				res.status = STS_EMPTY;
			end else begin
				res.out_payload = 16'(pick ? rd1[PAYLOAD_BITS-1:0] : rd0[PAYLOAD_BITS-1:0]);
				res.out_class   = pick;
				pop0 = commit && !pick;
				pop1 = commit && pick;
			end
		end
	end

	// Request capture; payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req.cmd;
			cls_q <= req.item_class;
			pay_q <= PAYLOAD_BITS'(req.payload_id);
		end
	end

	// Pointers, counts and the arrival sequence counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head0_q <= '0;
			tail0_q <= '0;
			cnt0_q  <= '0;
			head1_q <= '0;
			tail1_q <= '0;
			cnt1_q  <= '0;
			seq_q   <= '0;
		end else begin
			if (push0) begin
				tail0_q <= (tail0_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail0_q + 1'b1;
				cnt0_q  <= cnt0_q + 1'b1;
			end
			if (push1) begin
				tail1_q <= (tail1_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail1_q + 1'b1;
				cnt1_q  <= cnt1_q + 1'b1;
			end
			if (push0 || push1) begin
				seq_q <= seq_q + 1'b1;
			end
			if (pop0) begin
				head0_q <= (head0_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head0_q + 1'b1;
				cnt0_q  <= cnt0_q - 1'b1;
			end
			if (pop1) begin
				head1_q <= (head1_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head1_q + 1'b1;
				cnt1_q  <= cnt1_q - 1'b1;
			end
		end
	end

	// Sequencer state and the response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (commit) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// An empty queue has its head and tail pointers together.
	`TFQ_ASSERT_IMPL(a_empty0_ptrs, clk, arst_n, cnt0_q == '0, head0_q == tail0_q, "class 0 empty with pointers apart")
	`TFQ_ASSERT_IMPL(a_empty1_ptrs, clk, arst_n, cnt1_q == '0, head1_q == tail1_q, "class 1 empty with pointers apart")
	// Counts never pass the queue depth.
	`TFQ_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, (cnt0_q <= CntW'(QUEUE_DEPTH)) && (cnt1_q <= CntW'(QUEUE_DEPTH)), "queue count beyond depth")
	// A committed request leaves a valid response and frees the sequencer.
	`TFQ_ASSERT_NEXT(a_commit_rsp, clk, arst_n, commit, rsp_valid_q && (state_q == ST_IDLE), "commit without response")
	// The sequence counter moves only together with a push.
	`TFQ_ASSERT_NEXT(a_seq_push, clk, arst_n, !(push0 || push1), $stable(seq_q), "sequence moved without push")

endmodule

FILE: bench/tb.sv
// Self-checking testbench for two_class_fifo_oldest_first: directed script and random
// traffic, checked against an in-bench queue model or, for known script rows, hand-typed responses.
// Depends on tfq_pkg and the two_class_fifo_oldest_first RTL; reads no files.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tfq_pkg::*;

	// The command encoding leaves code three unused; the block must ignore it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int unsigned QueueDepth = QueueDepthDefault;
	localparam int unsigned CycleLimit = 2_000_000;
	// Cycles run once the response queue is empty, so that the block can go quiet.
	localparam int unsigned TailCycles = 10;
	// Responses seen before the receiver takes one long break, and its length.
	localparam int unsigned HoldAfterRsp = 300;
	localparam int unsigned HoldCycles = 120;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	two_class_fifo_oldest_first dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Queue model: one FIFO of (payload, arrival tag) per class plus the shared
	// arrival counter. It is updated at the edge where a request is accepted, so
	// its occupancy always matches what the block has been told so far.
	typedef struct packed {
		logic [15:0] pay;
		logic [15:0] tag;
	} slot_t;

	slot_t lane0_q[$];
	slot_t lane1_q[$];
	logic [15:0] next_tag;

	// Responses the block still owes, oldest first.
	rsp_t outstanding_rsp[$];

	int unsigned sender_idle_pct;
	int unsigned rcv_stall_pct;
	int unsigned error_count = 0;
	int unsigned rsp_total = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;

	// One row of the directed script. A row with known set carries the response
	// typed in by hand; otherwise the model supplies it. A push row repeated
	// several times bumps the payload by one per repetition.
	typedef struct packed {
		req_t       r;
		logic [4:0] reps;
		logic       known;
		rsp_t       want;
	} script_row_t;

	localparam int NumRows = 20;
	script_row_t script [NumRows] = '{
		// Every kind of pop on a freshly reset block reports empty.
		'{'{CMD_POP,     1'b0, 16'h0000}, 5'd1,  1'b1, '{STS_EMPTY, 16'h0000, 1'b0}},
		'{'{CMD_POP,     1'b1, 16'hFFFF}, 5'd1,  1'b1, '{STS_EMPTY, 16'h0000, 1'b0}},
		'{'{CMD_POP_ANY, 1'b0, 16'h0000}, 5'd1,  1'b1, '{STS_EMPTY, 16'h0000, 1'b0}},
		// The unused code is a no-op that still answers ok.
		'{'{CMD_UNUSED,  1'b1, 16'hFFFF}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b0}},
		// Pushes answer ok with zero fields; the oldest head leaves first.
		'{'{CMD_PUSH,    1'b0, 16'hFFFF}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_PUSH,    1'b1, 16'h0000}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_PUSH,    1'b1, 16'h8001}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_POP_ANY, 1'b1, 16'h1234}, 5'd1,  1'b1, '{STS_OK,    16'hFFFF, 1'b0}},
		'{'{CMD_POP_ANY, 1'b0, 16'h0000}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b1}},
		// Class 1 now holds the older head even though class 0 was pushed last.
		'{'{CMD_PUSH,    1'b0, 16'h5555}, 5'd1,  1'b1, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_POP_ANY, 1'b0, 16'h0000}, 5'd1,  1'b1, '{STS_OK,    16'h8001, 1'b1}},
		'{'{CMD_POP,     1'b1, 16'h0000}, 5'd1,  1'b1, '{STS_EMPTY, 16'h0000, 1'b0}},
		'{'{CMD_POP,     1'b0, 16'hFFFF}, 5'd1,  1'b1, '{STS_OK,    16'h5555, 1'b0}},
		// Fill class 0, then one more push must be refused.
		'{'{CMD_PUSH,    1'b0, 16'h1000}, 5'd16, 1'b0, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_PUSH,    1'b0, 16'hAAAA}, 5'd1,  1'b1, '{STS_FULL,  16'h0000, 1'b0}},
		'{'{CMD_PUSH,    1'b1, 16'h2000}, 5'd3,  1'b0, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_POP_ANY, 1'b1, 16'h0000}, 5'd6,  1'b0, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_POP,     1'b1, 16'h0000}, 5'd2,  1'b0, '{STS_OK,    16'h0000, 1'b0}},
		// Drain both classes and run past empty.
		'{'{CMD_POP_ANY, 1'b0, 16'h0000}, 5'd16, 1'b0, '{STS_OK,    16'h0000, 1'b0}},
		'{'{CMD_POP,     1'b0, 16'h0000}, 5'd1,  1'b1, '{STS_EMPTY, 16'h0000, 1'b0}}
	};

	// Class whose head is older by wraparound tag compare. An empty class 1, or
	// equal tags, gives class 0.
	function automatic logic oldest_class();
		logic [15:0] diff;
		if (lane1_q.size() == 0)
			return 1'b0;
		if (lane0_q.size() == 0)
			return 1'b1;
		diff = lane1_q[0].tag - lane0_q[0].tag;
		return diff[15];
	endfunction

	// Applies one accepted request to the queue model and returns the response
	// the block must produce for it.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		logic lane;
		slot_t s;
		res = '0;
		if (r.cmd == CMD_PUSH) begin
			if ((r.item_class ? lane1_q.size() : lane0_q.size()) >= QueueDepth) begin
				res.status = STS_FULL;
			end else begin
				s.pay = r.payload_id;
				s.tag = next_tag;
				if (r.item_class)
					lane1_q.push_back(s);
				else
					lane0_q.push_back(s);
				next_tag = next_tag + 16'd1;
			end
		end else if (r.cmd == CMD_POP || r.cmd == CMD_POP_ANY) begin
			lane = (r.cmd == CMD_POP) ? r.item_class : oldest_class();
			if ((lane ? lane1_q.size() : lane0_q.size()) == 0) begin
				res.status = STS_EMPTY;
			end else begin
				if (lane)
					s = lane1_q.pop_front();
				else
					s = lane0_q.pop_front();
				res.status = STS_OK;
				res.out_payload = s.pay;
				res.out_class = lane;
			end
		end
		return res;
	endfunction

	// Offers one request, with random idle cycles in front of it, and holds it
	// until the block takes it. Valid is only lowered inside the idle loop, so a
	// back-to-back request never sees valid drop and rise within one time step.
	task automatic offer(input req_t r, input bit known, input rsp_t want);
		rsp_t model;
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		model = apply_request(r);
		outstanding_rsp.push_back(known ? want : model);
	endtask

	// The sender goes quiet until every owed response has arrived.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding_rsp.size() != 0);
	endtask

	// Random traffic. The push share and the class choice change every 40
	// transactions so that queues regularly run full and run dry, which is where
	// the refusals and the pop-any arbitration get interesting.
	task automatic run_random(input int unsigned count);
		req_t r;
		int unsigned push_pct;
		int unsigned class_mode;
		int unsigned roll;
		push_pct = 50;
		class_mode = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 20;
					1: push_pct = 50;
					default: push_pct = 85;
				endcase
				class_mode = $urandom_range(3);
			end
			roll = $urandom_range(99);
			if (class_mode == 1)
				r.item_class = 1'b0;
			else if (class_mode == 2)
				r.item_class = 1'b1;
			else
				r.item_class = 1'($urandom);
			if ($urandom_range(15) == 0)
				r.payload_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
			else
				r.payload_id = 16'($urandom);
			if (roll < 3)
				r.cmd = CMD_UNUSED;
			else if (roll < 3 + push_pct)
				r.cmd = CMD_PUSH;
			else if ($urandom_range(1))
				r.cmd = CMD_POP;
			else
				r.cmd = CMD_POP_ANY;
			offer(r, 1'b0, '0);
		end
	endtask

	// Response side: checks every accepted transaction against the oldest owed
	// response and decides the stall for the next cycle. After a fixed number of
	// responses it holds off for a long stretch so the output register and the
	// execute stage fill and the block has to stall its request side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				rsp_total = rsp_total + 1;
				if (rsp_total == HoldAfterRsp)
					hold_left = HoldCycles;
				if (outstanding_rsp.size() == 0) begin
					error_count = error_count + 1;
					$display("%0t: unexpected response: got status %0d payload %h class %0d",
						$realtime, rsp.status, rsp.out_payload, rsp.out_class);
				end else begin
					rsp_t want;
					want = outstanding_rsp.pop_front();
					if (rsp.status !== want.status || rsp.out_payload !== want.out_payload ||
						rsp.out_class !== want.out_class) begin
						error_count = error_count + 1;
						$display("%0t: response mismatch: ", $realtime,
							"expected status %0d payload %h class %0d, ",
							want.status, want.out_payload, want.out_class,
							"got status %0d payload %h class %0d",
							rsp.status, rsp.out_payload, rsp.out_class);
					end
				end
			end
			if (hold_left != 0) begin
				rsp_stall <= 1'b1;
				hold_left = hold_left - 1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rcv_stall_pct);
			end
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CycleLimit) begin
			$display("%0t: watchdog expired with %0d responses outstanding",
				$realtime, outstanding_rsp.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		req_t r;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		next_tag = '0;
		// Phase one: sender mostly busy, receiver mostly stalling.
		sender_idle_pct = 22;
		rcv_stall_pct = 87;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script; repeated push rows count the payload up.
		for (int i = 0; i < NumRows; i++) begin
			for (int k = 0; k < script[i].reps; k++) begin
				r = script[i].r;
				r.payload_id = r.payload_id + 16'(k);
				offer(r, script[i].known, script[i].want);
			end
		end
		run_random(400);
		wait_drained();

		// Phase two: the other way round.
		sender_idle_pct = 87;
		rcv_stall_pct = 22;
		run_random(400);
		wait_drained();

		// Phase three: full rate on both sides.
		sender_idle_pct = 0;
		rcv_stall_pct = 0;
		run_random(392);

		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/tfq_pkg.sv
hw/rtl/tfq_ram.sv
hw/rtl/two_class_fifo_oldest_first.sv
bench/tb.sv
